@@ sv/dht_pkg.sv @@
// ----------------------------------------------------------------------------
// dht_pkg
// Shared types and constants of the double-hashing record table.
// ----------------------------------------------------------------------------
package dht_pkg;

  // Defaults of the top-level parameters.
  localparam int DefMaxSlots = 1024;
  localparam int DefKeyBytes = 9;

  // Reset values of the configuration registers.
  localparam logic [10:0] SlotCountReset = 11'd1021;
  localparam logic [10:0] StepPrimeReset = 11'd211;

  // Operation carried in the input tuser.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status carried in the output tuser.
  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_FOUND  = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_SLOT_COUNT = 1'b0,
    REG_STEP_PRIME = 1'b1
  } reg_idx_t;

endpackage

@@ sv/dht_ram.sv @@
// ----------------------------------------------------------------------------
// dht_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/dht_fifo.sv @@
// ----------------------------------------------------------------------------
// dht_fifo
// Two-entry queue that decouples the hashing front end from the probe engine.
// ----------------------------------------------------------------------------
module dht_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/dht_front.sv @@
// ----------------------------------------------------------------------------
// dht_front
// Accepts items, normalizes the key, computes the home slot and the probe
// step with bit-serial modular multiplications, and queues the job.
// ----------------------------------------------------------------------------
module dht_front import dht_pkg::*; #(
  parameter int MAX_SLOTS = DefMaxSlots,
  parameter int KEY_BYTES = DefKeyBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] slot_count,
  input  logic [10:0] step_prime,
  input  logic        start,
  output logic        idle,
  input  op_t         in_kind,
  input  logic [71:0] in_key,
  input  logic [71:0] in_name,
  input  logic [31:0] in_avg,
  output logic        job_valid,
  input  logic        job_ready,
  output logic [$clog2(MAX_SLOTS+1)+2*$clog2(MAX_SLOTS)+178-1:0] job_data
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int MW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic [MW-1:0] m;
    logic [AW-1:0] step;
    logic [AW-1:0] home;
    logic [31:0]   avg;
    logic [71:0]   name;
    logic [71:0]   key;
    op_t           kind;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_DIV, F_PUSH} fstate_t;

  fstate_t       state_r, state_nxt;
  op_t           kind_r, kind_nxt;
  logic [71:0]   key_r, key_nxt;
  logic [71:0]   name_r, name_nxt;
  logic [31:0]   avg_r, avg_nxt;
  logic [MW-1:0] m_r, m_nxt;
  logic [10:0]   r_r, r_nxt;
  logic [MW-1:0] res_m_r, res_m_nxt;
  logic [10:0]   res_r_r, res_r_nxt;
  logic [MW-1:0] acc_m_r, acc_m_nxt;
  logic [10:0]   acc_r_r, acc_r_nxt;
  logic [3:0]    byte_r, byte_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [10:0]   stepv_r, stepv_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [3:0]    cnt_r, cnt_nxt;

  logic [71:0]   norm_key;
  logic          alive;
  logic [7:0]    kb;
  logic [31:0]   sc32;
  logic [MW-1:0] m_eff;
  logic [10:0]   r_eff;
  logic [79:0]   key_ext;
  logic [7:0]    cur_byte;
  logic          cur_bit;
  logic [MW:0]   dm, em;
  logic [11:0]   dr, er;
  logic [MW:0]   rsh;
  logic [10:0]   step_raw;
  job_t          job;

  // Key normalization: keep bytes up to the first zero and below KEY_BYTES.
  always_comb begin
    norm_key = '0;
    alive    = 1'b1;
    for (int i = 0; i < 9; i++) begin
      kb = in_key[8*i +: 8];
      if (kb == 8'h00 || i >= KEY_BYTES) begin
        alive = 1'b0;
      end
      if (alive) begin
        norm_key[8*i +: 8] = kb;
      end
    end
  end

  // Effective moduli from the configuration registers.
  always_comb begin
    sc32 = 32'(slot_count);
    if (sc32 == 32'd0) begin
      m_eff = MW'(1);
    end else if (sc32 > 32'(MAX_SLOTS)) begin
      m_eff = MW'(MAX_SLOTS);
    end else begin
      m_eff = MW'(sc32);
    end
    r_eff = (step_prime == 11'd0) ? 11'd1 : step_prime;
  end

  // One Horner step of (res * byte) mod m and mod r per cycle.
  always_comb begin
    key_ext  = {8'h00, key_r};
    cur_byte = key_ext[{byte_r, 3'b000} +: 8];
    cur_bit  = cur_byte[bit_r];
    dm = {acc_m_r, 1'b0};
    if (dm >= (MW+1)'(m_r)) dm = dm - (MW+1)'(m_r);
    em = dm + (cur_bit ? (MW+1)'(res_m_r) : '0);
    if (em >= (MW+1)'(m_r)) em = em - (MW+1)'(m_r);
    dr = {acc_r_r, 1'b0};
    if (dr >= 12'(r_r)) dr = dr - 12'(r_r);
    er = dr + (cur_bit ? 12'(res_r_r) : 12'd0);
    if (er >= 12'(r_r)) er = er - 12'(r_r);
    // Restoring division step for the step reduced modulo m.
    rsh = {rem_r, stepv_r[cnt_r]};
    if (rsh >= (MW+1)'(m_r)) rsh = rsh - (MW+1)'(m_r);
    step_raw = r_r - res_r_r;
    if (step_raw == 11'd0) step_raw = 11'd1;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    key_nxt   = key_r;
    name_nxt  = name_r;
    avg_nxt   = avg_r;
    m_nxt     = m_r;
    r_nxt     = r_r;
    res_m_nxt = res_m_r;
    res_r_nxt = res_r_r;
    acc_m_nxt = acc_m_r;
    acc_r_nxt = acc_r_r;
    byte_nxt  = byte_r;
    bit_nxt   = bit_r;
    stepv_nxt = stepv_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          key_nxt   = norm_key;
          name_nxt  = in_name;
          avg_nxt   = in_avg;
          m_nxt     = m_eff;
          r_nxt     = r_eff;
          res_m_nxt = (m_eff == MW'(1)) ? '0 : MW'(1);
          res_r_nxt = (r_eff == 11'd1) ? 11'd0 : 11'd1;
          acc_m_nxt = '0;
          acc_r_nxt = '0;
          byte_nxt  = 4'd0;
          bit_nxt   = 3'd7;
          m_nxt     = m_eff;
          case (in_kind)
            OP_INSERT, OP_LOOKUP: state_nxt = F_HASH;
            OP_CLEAR:             state_nxt = F_PUSH;
            default:              state_nxt = F_IDLE;
          endcase
        end
      end
      F_HASH: begin
        if (cur_byte == 8'h00) begin
          stepv_nxt = step_raw;
          rem_nxt   = '0;
          cnt_nxt   = 4'd10;
          state_nxt = F_DIV;
        end else if (bit_r == 3'd0) begin
          res_m_nxt = em[MW-1:0];
          res_r_nxt = er[10:0];
          acc_m_nxt = '0;
          acc_r_nxt = '0;
          byte_nxt  = byte_r + 4'd1;
          bit_nxt   = 3'd7;
        end else begin
          acc_m_nxt = em[MW-1:0];
          acc_r_nxt = er[10:0];
          bit_nxt   = bit_r - 3'd1;
        end
      end
      F_DIV: begin
        rem_nxt = rsh[MW-1:0];
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    name_r  <= name_nxt;
    avg_r   <= avg_nxt;
    m_r     <= m_nxt;
    r_r     <= r_nxt;
    res_m_r <= res_m_nxt;
    res_r_r <= res_r_nxt;
    acc_m_r <= acc_m_nxt;
    acc_r_r <= acc_r_nxt;
    byte_r  <= byte_nxt;
    bit_r   <= bit_nxt;
    stepv_r <= stepv_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
  end

  // Job handed to the probe engine.
  always_comb begin
    job.m    = m_r;
    job.step = rem_r[AW-1:0];
    job.home = res_m_r[AW-1:0];
    job.avg  = avg_r;
    job.name = name_r;
    job.key  = key_r;
    job.kind = kind_r;
  end

  assign job_data  = job;
  assign job_valid = (state_r == F_PUSH);
  assign idle      = (state_r == F_IDLE);

endmodule

@@ sv/dht_probe.sv @@
// ----------------------------------------------------------------------------
// dht_probe
// Probe engine: walks the double-hash path through the slot RAM, inserts or
// matches records, runs clearing sweeps and holds the result register.
// ----------------------------------------------------------------------------
module dht_probe import dht_pkg::*; #(
  parameter int MAX_SLOTS = DefMaxSlots
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          init_busy,
  input  logic          job_valid,
  output logic          job_ready,
  input  logic [$clog2(MAX_SLOTS+1)+2*$clog2(MAX_SLOTS)+178-1:0] job_data,
  output logic          out_valid,
  input  logic          out_ready,
  output status_t       out_status,
  output logic [9:0]    out_slot,
  output logic [9:0]    out_home,
  output logic [10:0]   out_probes,
  output logic [71:0]   out_name,
  output logic [31:0]   out_avg
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int MW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    logic [MW-1:0] m;
    logic [AW-1:0] step;
    logic [AW-1:0] home;
    logic [31:0]   avg;
    logic [71:0]   name;
    logic [71:0]   key;
    op_t           kind;
  } job_t;

  typedef struct packed {
    logic          used;
    logic [AW-1:0] home;
    logic [31:0]   avg;
    logic [71:0]   name;
    logic [71:0]   key;
  } word_t;

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD, B_CHK, B_CLR, B_RES} bstate_t;

  localparam int WW = $bits(word_t);

  bstate_t       state_r, state_nxt;
  job_t          job_r, job_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [MW-1:0] cnt_r, cnt_nxt;
  status_t       rs_status_r, rs_status_nxt;
  logic [AW-1:0] rs_slot_r, rs_slot_nxt;
  logic [AW-1:0] rs_home_r, rs_home_nxt;
  logic [MW-1:0] rs_probes_r, rs_probes_nxt;
  logic [71:0]   rs_name_r, rs_name_nxt;
  logic [31:0]   rs_avg_r, rs_avg_nxt;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  logic [9:0]    out_slot_r, out_home_r;
  logic [10:0]   out_probes_r;
  logic [71:0]   out_name_r;
  logic [31:0]   out_avg_r;

  job_t          job_in;
  word_t         rword, wword;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata, ram_rdata;
  logic          hit;
  logic [MW:0]   pos_sum;
  logic [MW-1:0] cnt_inc;
  logic          load_out;

  assign job_in = job_data;
  assign rword  = ram_rdata;

  dht_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Probe evaluation and next position on the path.
  always_comb begin
    if (job_r.kind == OP_INSERT) begin
      hit = !rword.used;
    end else begin
      hit = rword.used && (rword.key == job_r.key);
    end
    pos_sum = (MW+1)'(pos_r) + (MW+1)'(job_r.step);
    if (pos_sum >= (MW+1)'(job_r.m)) pos_sum = pos_sum - (MW+1)'(job_r.m);
    cnt_inc = cnt_r + MW'(1);
    wword.used = 1'b1;
    wword.home = job_r.home;
    wword.avg  = job_r.avg;
    wword.name = job_r.name;
    wword.key  = job_r.key;
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    rs_status_nxt = rs_status_r;
    rs_slot_nxt   = rs_slot_r;
    rs_home_nxt   = rs_home_r;
    rs_probes_nxt = rs_probes_r;
    rs_name_nxt   = rs_name_r;
    rs_avg_nxt    = rs_avg_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = '0;
    load_out      = 1'b0;
    case (state_r)
      B_INIT, B_CLR: begin
        ram_we  = 1'b1;
        pos_nxt = pos_r + AW'(1);
        if (pos_r == AW'(MAX_SLOTS - 1)) begin
          rs_status_nxt = ST_MISS;
          rs_slot_nxt   = '0;
          rs_home_nxt   = '0;
          rs_probes_nxt = '0;
          rs_name_nxt   = '0;
          rs_avg_nxt    = '0;
          state_nxt     = (state_r == B_INIT) ? B_IDLE : B_RES;
        end
      end
      B_IDLE: begin
        if (job_valid) begin
          job_nxt = job_in;
          cnt_nxt = '0;
          if (job_in.kind == OP_CLEAR) begin
            pos_nxt   = '0;
            state_nxt = B_CLR;
          end else begin
            pos_nxt   = job_in.home;
            state_nxt = B_RD;
          end
        end
      end
      B_RD: begin
        ram_re    = 1'b1;
        state_nxt = B_CHK;
      end
      B_CHK: begin
        rs_home_nxt = job_r.home;
        rs_name_nxt = '0;
        rs_avg_nxt  = '0;
        if (hit) begin
          rs_slot_nxt   = pos_r;
          rs_probes_nxt = cnt_inc;
          if (job_r.kind == OP_INSERT) begin
            ram_we        = 1'b1;
            ram_wdata     = wword;
            rs_status_nxt = ST_STORED;
          end else begin
            rs_status_nxt = ST_FOUND;
            rs_name_nxt   = rword.name;
            rs_avg_nxt    = rword.avg;
          end
          state_nxt = B_RES;
        end else if (cnt_inc == job_r.m) begin
          rs_slot_nxt   = '0;
          rs_probes_nxt = job_r.m;
          rs_status_nxt = (job_r.kind == OP_INSERT) ? ST_FULL : ST_MISS;
          state_nxt     = B_RES;
        end else begin
          cnt_nxt   = cnt_inc;
          pos_nxt   = pos_sum[AW-1:0];
          state_nxt = B_RD;
        end
      end
      B_RES: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
    job_r       <= job_nxt;
    cnt_r       <= cnt_nxt;
    rs_status_r <= rs_status_nxt;
    rs_slot_r   <= rs_slot_nxt;
    rs_home_r   <= rs_home_nxt;
    rs_probes_r <= rs_probes_nxt;
    rs_name_r   <= rs_name_nxt;
    rs_avg_r    <= rs_avg_nxt;
  end

  // Output register, loaded when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= rs_status_r;
      out_slot_r   <= 10'(rs_slot_r);
      out_home_r   <= 10'(rs_home_r);
      out_probes_r <= 11'(rs_probes_r);
      out_name_r   <= rs_name_r;
      out_avg_r    <= rs_avg_r;
    end
  end

  assign job_ready  = (state_r == B_IDLE);
  assign init_busy  = (state_r == B_INIT);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_home   = out_home_r;
  assign out_probes = out_probes_r;
  assign out_name   = out_name_r;
  assign out_avg    = out_avg_r;

endmodule

@@ sv/double_hash_table.sv @@
// ----------------------------------------------------------------------------
// double_hash_table
// Open-addressed record table with double hashing: insert, lookup and clear.
// ----------------------------------------------------------------------------
//  Channel | Direction | tuser        | tdata
//  in_     | slave     | kind (2)     | key, name, average (176 bits)
//  out_    | master    | status (2)   | slot, home, probes, name, average (136)
//  cfg_    | write     | -            | index 0 slot_count, 1 step_prime
//
//  Hashing walks each key byte bit by bit up to the first zero byte, sees the
//  end of the key and then reduces the probe step by restoring division; the
//  probe engine examines each slot in a read state (B_RD) and a check state
//  (B_CHK), since the RAM read is registered.
//  A clear item sweeps all MAX_SLOTS slots of the RAM. After reset the same
//  sweep runs with in_tready low.
//  The front end hashes the next item while the engine probes; the output
//  register lets both continue while a result waits on out_tready.
// ----------------------------------------------------------------------------
module double_hash_table import dht_pkg::*; #(
  parameter int MAX_SLOTS = DefMaxSlots,
  parameter int KEY_BYTES = DefKeyBytes
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // kind
  input  logic [175:0] in_tdata,   // key_low, key_high, name_low, name_high, average_bits
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [135:0] out_tdata,  // slot_index, home_slot, probe_count,
                                   // found_name_low, found_name_high, found_average
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [10:0]  cfg_wdata
);

  localparam int AW = $clog2(MAX_SLOTS);
  localparam int MW = $clog2(MAX_SLOTS + 1);
  localparam int JW = MW + 2 * AW + 178;

  logic [10:0]   slot_count_r, slot_count_nxt;
  logic [10:0]   step_prime_r, step_prime_nxt;
  logic          front_idle, init_busy, start;
  logic          q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  logic [JW-1:0] q_in_data, q_out_data;
  status_t       res_status;
  logic [9:0]    res_slot, res_home;
  logic [10:0]   res_probes;
  logic [71:0]   res_name;
  logic [31:0]   res_avg;

  // Configuration registers.
  always_comb begin
    slot_count_nxt = slot_count_r;
    step_prime_nxt = step_prime_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SLOT_COUNT: slot_count_nxt = cfg_wdata;
        REG_STEP_PRIME: step_prime_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SlotCountReset;
      step_prime_r <= StepPrimeReset;
    end else begin
      slot_count_r <= slot_count_nxt;
      step_prime_r <= step_prime_nxt;
    end
  end

  // Input transaction is taken when the front end is idle and init is done.
  assign in_tready = front_idle && !init_busy;
  assign start     = in_tvalid && in_tready;

  dht_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .slot_count (slot_count_r),
    .step_prime (step_prime_r),
    .start      (start),
    .idle       (front_idle),
    .in_kind    (op_t'(in_tuser)),
    .in_key     (in_tdata[71:0]),
    .in_name    (in_tdata[143:72]),
    .in_avg     (in_tdata[175:144]),
    .job_valid  (q_in_valid),
    .job_ready  (q_in_ready),
    .job_data   (q_in_data)
  );

  dht_fifo #(
    .WIDTH (JW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  dht_probe #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_probe (
    .clk        (clk),
    .rst_n      (rst_n),
    .init_busy  (init_busy),
    .job_valid  (q_out_valid),
    .job_ready  (q_out_ready),
    .job_data   (q_out_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_slot   (res_slot),
    .out_home   (res_home),
    .out_probes (res_probes),
    .out_name   (res_name),
    .out_avg    (res_avg)
  );

  // Result packing, first field in the low bits.
  assign out_tuser = res_status;
  assign out_tdata = {1'b0, res_avg, res_name, res_probes, res_home, res_slot};

endmodule
